>>> rtl/rpbp_pkg.sv
// rpbp_pkg: types, constants and helper functions shared by the rgba pixel bit packer
// depends on nothing; used by every module in rtl/ except rpbp_checker

package rpbp_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_BIT_COUNT   = 3'd0,
        REG_RED_MASK    = 3'd1,
        REG_GREEN_MASK  = 3'd2,
        REG_BLUE_MASK   = 3'd3,
        REG_ALPHA_MASK  = 3'd4,
        REG_PITCH_ALIGN = 3'd5
    } reg_index_t;

    localparam int NUM_CHAN = 4;

    localparam logic [5:0]  BIT_COUNT_RESET = 6'd32;
    localparam logic [5:0]  BIT_COUNT_MAX   = 6'd32;
    localparam logic [4:0]  PITCH_RESET     = 5'd1;
    localparam logic [31:0] RED_RESET       = 32'h00FF_0000;
    localparam logic [31:0] GREEN_RESET     = 32'h0000_FF00;
    localparam logic [31:0] BLUE_RESET      = 32'h0000_00FF;
    localparam logic [31:0] ALPHA_RESET     = 32'hFF00_0000;

    // smallest positive input whose scaled value would pass full scale
    localparam logic [31:0] SAT_LEVEL = 32'd65794;
    localparam logic [7:0]  CHAN_FULL = 8'hFF;
    localparam logic [24:0] CHAN_SCALE = 25'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // decoded channel mask: the contiguous run and the index of its top bit
    typedef struct packed {
        logic [31:0] run;
        logic [4:0]  top;
    } mask_info_t;

    typedef struct packed {
        logic [5:0]                      bit_count;
        mask_info_t [NUM_CHAN-1:0]       info;
    } cfg_t;

    typedef struct packed {
        logic [31:0] word;
        logic        row_end;
    } qentry_t;

    // run of ones that starts at the lowest set bit
    function automatic logic [31:0] mask_run(input logic [31:0] m);
        logic [31:0] lowbit;
        logic [32:0] sum;
        begin
            lowbit = m & (~m + 32'd1);
            sum    = {1'b0, m} + {1'b0, lowbit};
            return m & ~sum[31:0];
        end
    endfunction

    // index of the top bit of a run, zero for an empty run
    function automatic logic [4:0] run_top(input logic [31:0] run);
        logic [31:0] hi;
        logic [4:0]  idx;
        begin
            hi  = run & ~(run >> 1);
            idx = 5'd0;
            for (int i = 0; i < 32; i++)
            begin
                if (hi[i])
                    idx = idx | 5'(i);
            end
            return idx;
        end
    endfunction

    // s15.16 times 255, truncated, clamped to 0..255
    function automatic logic [7:0] to_u8(input logic [31:0] v);
        logic [24:0] prod;
        begin
            prod = {8'd0, v[16:0]} * CHAN_SCALE;
            if (v[31] || v == 32'd0)
                return 8'd0;
            else if (v >= SAT_LEVEL)
                return CHAN_FULL;
            else
                return prod[23:16];
        end
    endfunction

    // widen or narrow to the run length and put it under the run
    function automatic logic [31:0] place_chan(input logic [7:0] c, input mask_info_t info);
        logic [31:0] pat;
        begin
            pat = {c, c, c, c};
            return (pat >> (5'd31 - info.top)) & info.run;
        end
    endfunction

endpackage

>>> rtl/rgba_pixel_bit_packer.sv
// rgba_pixel_bit_packer: top level, packs rgba fixed point pixels into a masked byte stream
// depends on rpbp_pkg, rpbp_cfg, rpbp_front, rpbp_queue, rpbp_back
//
// channel   direction  handshake            payload
// in        to block   in_valid / in_stall    red, green, blue, alpha, row_end
// out       from block out_valid / out_stall  data_byte, last_byte
// cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a pixel makes as many bytes as its bits complete, plus a flush byte and zero pad
// bytes at a row end; the byte sequencer sends one byte a cycle while the output is
// not stalled, and at a row end the flush and pad bytes follow the pixel's data bytes
// the front registers scale, then place, ahead of a 4-entry queue
// reset is asynchronous and clears the bit buffer, fill count and row phase; no sweep
// out_stall holds the output register and backs up through the queue into in_stall

module rgba_pixel_bit_packer #(
    parameter int MAX_ALIGNMENT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] red,
    input  logic [31:0] green,
    input  logic [31:0] blue,
    input  logic [31:0] alpha,
    input  logic        row_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    rpbp_pkg::cfg_t                      cfg;
    logic [4:0]                          pitch_alignment;
    logic                                in_accept;
    logic                                push;
    rpbp_pkg::qentry_t                   push_entry;
    logic [1:0]                          inflight;
    logic                                pop;
    logic                                head_valid;
    rpbp_pkg::qentry_t                   head;
    logic [rpbp_pkg::QCNT_W-1:0]         q_count;
    logic [rpbp_pkg::QCNT_W:0]           occupancy;

    // credit check: queue entries plus pixels still in the front never exceed the queue
    assign occupancy = (rpbp_pkg::QCNT_W+1)'(q_count) + (rpbp_pkg::QCNT_W+1)'(inflight);
    assign in_stall  = (occupancy >= (rpbp_pkg::QCNT_W+1)'(rpbp_pkg::QUEUE_DEPTH));
    assign in_accept = in_valid && !in_stall;

    // configuration registers, mask runs decoded as they are written
    rpbp_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cfg             (cfg),
        .pitch_alignment (pitch_alignment)
    );

    // front: channel scaling and placement into one pixel word
    rpbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .row_end    (row_end),
        .cfg        (cfg),
        .push       (push),
        .push_entry (push_entry),
        .inflight   (inflight)
    );

    // decoupling queue of pixel words
    rpbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    // back: bit buffer, byte emission, flush and row padding
    rpbp_back #(
        .MAX_ALIGNMENT (MAX_ALIGNMENT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .cfg             (cfg),
        .pitch_alignment (pitch_alignment),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .data_byte       (data_byte),
        .last_byte       (last_byte)
    );

endmodule

>>> rtl/rpbp_cfg.sv
// rpbp_cfg: configuration registers with mask decode on write
// depends on rpbp_pkg

module rpbp_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output rpbp_pkg::cfg_t       cfg,
    output logic [4:0]           pitch_alignment
);

    logic [5:0]  bit_count_reg;
    logic [4:0]  pitch_reg;
    logic [31:0] run_reg [rpbp_pkg::NUM_CHAN];
    logic [4:0]  top_reg [rpbp_pkg::NUM_CHAN];
    logic [31:0] run_wr;
    logic        wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign run_wr    = rpbp_pkg::mask_run(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= rpbp_pkg::BIT_COUNT_RESET;
            pitch_reg     <= rpbp_pkg::PITCH_RESET;
            run_reg[0]    <= rpbp_pkg::RED_RESET;
            run_reg[1]    <= rpbp_pkg::GREEN_RESET;
            run_reg[2]    <= rpbp_pkg::BLUE_RESET;
            run_reg[3]    <= rpbp_pkg::ALPHA_RESET;
            top_reg[0]    <= rpbp_pkg::run_top(rpbp_pkg::RED_RESET);
            top_reg[1]    <= rpbp_pkg::run_top(rpbp_pkg::GREEN_RESET);
            top_reg[2]    <= rpbp_pkg::run_top(rpbp_pkg::BLUE_RESET);
            top_reg[3]    <= rpbp_pkg::run_top(rpbp_pkg::ALPHA_RESET);
        end
        else if (wr_en)
        begin
            unique case (rpbp_pkg::reg_index_t'(cfg_index))
                rpbp_pkg::REG_BIT_COUNT:
                begin
                    bit_count_reg <= cfg_data[5:0];
                end
                rpbp_pkg::REG_RED_MASK:
                begin
                    run_reg[0] <= run_wr;
                    top_reg[0] <= rpbp_pkg::run_top(run_wr);
                end
                rpbp_pkg::REG_GREEN_MASK:
                begin
                    run_reg[1] <= run_wr;
                    top_reg[1] <= rpbp_pkg::run_top(run_wr);
                end
                rpbp_pkg::REG_BLUE_MASK:
                begin
                    run_reg[2] <= run_wr;
                    top_reg[2] <= rpbp_pkg::run_top(run_wr);
                end
                rpbp_pkg::REG_ALPHA_MASK:
                begin
                    run_reg[3] <= run_wr;
                    top_reg[3] <= rpbp_pkg::run_top(run_wr);
                end
                rpbp_pkg::REG_PITCH_ALIGN:
                begin
                    pitch_reg <= cfg_data[4:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.bit_count = (bit_count_reg > rpbp_pkg::BIT_COUNT_MAX) ?
                        rpbp_pkg::BIT_COUNT_MAX : bit_count_reg;
        for (int i = 0; i < rpbp_pkg::NUM_CHAN; i++)
        begin
            cfg.info[i].run = run_reg[i];
            cfg.info[i].top = top_reg[i];
        end
    end

    assign pitch_alignment = pitch_reg;

endmodule

>>> rtl/rpbp_front.sv
// rpbp_front: two-stage pixel converter, channel scaling then placement into the pixel word
// depends on rpbp_pkg

module rpbp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [31:0]          red,
    input  logic [31:0]          green,
    input  logic [31:0]          blue,
    input  logic [31:0]          alpha,
    input  logic                 row_end,
    input  rpbp_pkg::cfg_t       cfg,
    output logic                 push,
    output rpbp_pkg::qentry_t    push_entry,
    output logic [1:0]           inflight
);

    logic        s1_valid_reg;
    logic [7:0]  s1_chan_reg [rpbp_pkg::NUM_CHAN];
    logic        s1_row_end_reg;
    logic        s2_valid_reg;
    logic [31:0] s2_word_reg;
    logic        s2_row_end_reg;
    logic [31:0] word_next;
    logic [32:0] keep_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage 1: scale each channel to 8 bits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_chan_reg[0] <= rpbp_pkg::to_u8(red);
            s1_chan_reg[1] <= rpbp_pkg::to_u8(green);
            s1_chan_reg[2] <= rpbp_pkg::to_u8(blue);
            s1_chan_reg[3] <= rpbp_pkg::to_u8(alpha);
            s1_row_end_reg <= row_end;
        end
    end

    // stage 2: place under masks, merge, cut to bit_count
    always_comb
    begin
        keep_mask = (33'd1 << cfg.bit_count) - 33'd1;
        word_next = 32'd0;
        for (int i = 0; i < rpbp_pkg::NUM_CHAN; i++)
        begin
            word_next = word_next | rpbp_pkg::place_chan(s1_chan_reg[i], cfg.info[i]);
        end
        word_next = word_next & keep_mask[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_word_reg    <= word_next;
            s2_row_end_reg <= s1_row_end_reg;
        end
    end

    assign push               = s2_valid_reg;
    assign push_entry.word    = s2_word_reg;
    assign push_entry.row_end = s2_row_end_reg;
    assign inflight           = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

>>> rtl/rpbp_queue.sv
// rpbp_queue: short register queue between pixel converter and byte sequencer
// depends on rpbp_pkg

module rpbp_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  rpbp_pkg::qentry_t             push_entry,
    input  logic                          pop,
    output logic                          head_valid,
    output rpbp_pkg::qentry_t             head,
    output logic [rpbp_pkg::QCNT_W-1:0]   count
);

    rpbp_pkg::qentry_t                entry_reg [rpbp_pkg::QUEUE_DEPTH];
    logic [rpbp_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [rpbp_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [rpbp_pkg::QCNT_W-1:0]      count_reg;
    logic                             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

>>> rtl/rpbp_back.sv
// rpbp_back: bit buffer, byte sequencer (data, flush, row padding) and output register
// depends on rpbp_pkg

module rpbp_back #(
    parameter int MAX_ALIGNMENT = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  rpbp_pkg::qentry_t    head,
    output logic                 pop,
    input  rpbp_pkg::cfg_t       cfg,
    input  logic [4:0]           pitch_alignment,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           data_byte,
    output logic                 last_byte
);

    localparam int PW = (MAX_ALIGNMENT > 1) ? $clog2(MAX_ALIGNMENT) : 1;
    localparam int AW = ($clog2(MAX_ALIGNMENT + 1) > 5) ? $clog2(MAX_ALIGNMENT + 1) : 5;
    localparam logic [AW-1:0] ALIGN_MAX = AW'(MAX_ALIGNMENT);

    logic            busy_reg,    busy_next;
    logic [31:0]     data_reg,    data_next;
    logic [2:0]      left_reg,    left_next;
    logic            row_end_reg, row_end_next;
    logic [7:0]      bits_reg,    bits_next;
    logic [2:0]      fill_reg,    fill_next;
    logic [PW-1:0]   phase_reg,   phase_next;
    logic            out_valid_reg;
    logic [7:0]      out_data_reg;
    logic            out_last_reg;

    logic [AW-1:0]   align;
    logic            out_free;
    logic            emit;
    logic            emit_last;
    logic [7:0]      emit_data;
    logic [31:0]     data_e;
    logic [2:0]      left_e;
    logic [7:0]      bits_e;
    logic [2:0]      fill_e;
    logic [PW-1:0]   phase_e;
    logic            busy_e;
    logic [39:0]     acc;
    logic [39:0]     acc_rest;
    logic [5:0]      total;
    logic [2:0]      nbytes;
    logic [2:0]      fill_l;
    logic            more_l;

    // another pad byte is owed while the phase is inside the alignment
    function automatic logic pad_due(input logic [PW-1:0] ph, input logic [AW-1:0] al);
        logic [AW-1:0] ph_x;
        begin
            ph_x = AW'(ph);
            return (ph_x != '0) && (ph_x < al);
        end
    endfunction

    function automatic logic [PW-1:0] phase_step(input logic [PW-1:0] ph,
                                                 input logic [AW-1:0] al);
        logic [AW:0] p1;
        begin
            p1 = (AW+1)'(ph) + 1'b1;
            return (p1 >= {1'b0, al}) ? '0 : p1[PW-1:0];
        end
    endfunction

    always_comb
    begin
        if (AW'(pitch_alignment) == '0)
            align = AW'(1);
        else if (AW'(pitch_alignment) > ALIGN_MAX)
            align = ALIGN_MAX;
        else
            align = AW'(pitch_alignment);
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_data = 8'd0;
        data_e    = data_reg;
        left_e    = left_reg;
        bits_e    = bits_reg;
        fill_e    = fill_reg;
        phase_e   = phase_reg;
        busy_e    = busy_reg;

        // one byte a cycle while the output is free: data bytes, then at a row end the partial byte and zero padding
        if (busy_reg && out_free)
        begin
            if (left_reg != 3'd0)
            begin
                emit      = 1'b1;
                emit_data = data_reg[7:0];
                data_e    = {8'd0, data_reg[31:8]};
                left_e    = left_reg - 3'd1;
            end
            else if (row_end_reg && fill_reg != 3'd0)
            begin
                emit      = 1'b1;
                emit_data = bits_reg;
                bits_e    = 8'd0;
                fill_e    = 3'd0;
            end
            else if (row_end_reg && pad_due(phase_reg, align))
            begin
                emit      = 1'b1;
                emit_data = 8'd0;
            end
        end

        if (emit)
        begin
            phase_e   = phase_step(phase_reg, align);
            emit_last = !((left_e != 3'd0) ||
                          (row_end_reg && ((fill_e != 3'd0) || pad_due(phase_e, align))));
            if (emit_last)
            begin
                busy_e = 1'b0;
                if (row_end_reg)
                    phase_e = '0;
            end
        end

        pop = head_valid && !busy_e;

        // load the next pixel word on top of the post-emit buffer
        acc      = ({32'd0, bits_e} << cfg.bit_count) | {8'd0, head.word};
        total    = {3'd0, fill_e} + cfg.bit_count;
        nbytes   = total[5:3];
        fill_l   = total[2:0];
        acc_rest = acc >> {nbytes, 3'b000};
        more_l   = (nbytes != 3'd0) ||
                   (head.row_end && ((fill_l != 3'd0) || pad_due(phase_e, align)));

        busy_next    = busy_e;
        data_next    = data_e;
        left_next    = left_e;
        row_end_next = row_end_reg;
        bits_next    = bits_e;
        fill_next    = fill_e;
        phase_next   = phase_e;

        if (pop)
        begin
            busy_next    = more_l;
            data_next    = acc[31:0];
            left_next    = nbytes;
            row_end_next = head.row_end;
            bits_next    = acc_rest[7:0];
            fill_next    = fill_l;
            if (!more_l && head.row_end)
                phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            left_reg      <= 3'd0;
            row_end_reg   <= 1'b0;
            bits_reg      <= 8'd0;
            fill_reg      <= 3'd0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            left_reg    <= left_next;
            row_end_reg <= row_end_next;
            bits_reg    <= bits_next;
            fill_reg    <= fill_next;
            phase_reg   <= phase_next;
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (emit)
        begin
            out_data_reg <= emit_data;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = out_data_reg;
    assign last_byte = out_last_reg;

endmodule

>>> rtl/rpbp_checker.sv
// rpbp_checker: port-level assertions for rgba_pixel_bit_packer, bound to the top level
// depends on rgba_pixel_bit_packer ports only

module rpbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] data_byte,
    input logic       last_byte,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a stalled output transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(last_byte))
        else $error("output payload changed while stalled");

    // bytes of one pixel go out without gaps once the sink takes them
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_byte |=> out_valid)
        else $error("gap inside the bytes of one pixel");

    // configuration writes are never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write blocked");

endmodule

bind rgba_pixel_bit_packer rpbp_checker u_rpbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
